// ----- sv/rtpvp_pkg.sv -----
// ----------------------------------------------------------------------------
// rtpvp_pkg: shared types and constants of the RTP video header parser
// Request and result formats, status codes, codec and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtpvp_pkg;

  // Fixed RTP header size in bytes
  localparam int unsigned BASE_HEADER_BYTES = 12;

  // Header field masks
  localparam logic [7:0] CSRC_MASK   = 8'h0F;
  localparam logic [7:0] EXT_MASK    = 8'h10;
  localparam logic [7:0] KIND_MASK   = 8'h7F;
  localparam logic [7:0] NAL264_MASK = 8'h1F;
  localparam logic [7:0] START_MASK  = 8'h80;

  // NAL unit types that the parser inspects for frame start and marker handling
  localparam logic [5:0] NAL_SLICE     = 6'd1;
  localparam logic [5:0] NAL264_IDR    = 6'd5;
  localparam logic [5:0] NAL264_SEI    = 6'd6;
  localparam logic [5:0] NAL264_PPS    = 6'd8;
  localparam logic [5:0] NAL264_FU_A   = 6'd28;
  localparam logic [5:0] NAL265_IDR    = 6'd19;
  localparam logic [5:0] NAL265_FU     = 6'd49;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1500;
  localparam logic [15:0] INDEX_SAT         = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TOO_SHORT  = 2'd1,
    ST_HEADER_END = 2'd2,
    ST_TOO_LONG   = 2'd3
  } status_e;

  typedef enum logic {
    CODEC_H264 = 1'b0,
    CODEC_H265 = 1'b1
  } codec_e;

  typedef enum logic {
    CFG_CODEC_MODE  = 1'b0,
    CFG_MAX_PAYLOAD = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] packet_length;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    status_e     parse_status;
    logic        marker;
    logic [6:0]  payload_type;
    logic [15:0] sequence_number;
    logic [31:0] time_stamp;
    logic [31:0] source_id;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic [5:0]  nal_type;
    logic        frame_start;
    logic        result_valid_last;
  } res_item_t;

endpackage

// ----- sv/rtpvp_if.sv -----
// ----------------------------------------------------------------------------
// rtpvp_if: valid/ready channels of the RTP video header parser
// One channel for packet bytes, one for parse results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rtpvp_in_if;
  logic               valid;
  logic               ready;
  rtpvp_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rtpvp_res_if;
  logic                 valid;
  logic                 ready;
  rtpvp_pkg::res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/rtpvp_in_stage.sv -----
// ----------------------------------------------------------------------------
// rtpvp_in_stage: input register
// Captures one byte request per cycle and holds it until the core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtpvp_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rtpvp_in_if.sink             pkt_i,
  input  logic                 advance_i,
  output logic                 valid_o,
  output rtpvp_pkg::in_item_t  item_o
);

  logic                valid_q;
  rtpvp_pkg::in_item_t item_q;

  // Accept when empty or when the held request moves on this cycle
  assign pkt_i.ready = !valid_q || advance_i;

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pkt_i.ready) begin
      valid_q <= pkt_i.valid;
    end
  end

  // Load the payload on accept
  always_ff @(posedge clk_i) begin
    if (pkt_i.valid && pkt_i.ready) begin
      item_q <= pkt_i.data;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- sv/rtpvp_parse_core.sv -----
// ----------------------------------------------------------------------------
// rtpvp_parse_core: per-packet header state and result logic
// Tracks the byte index, captures header fields and payload head bytes, and
// forms the result for the last byte of a packet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtpvp_parse_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  rtpvp_pkg::in_item_t   item_i,
  input  logic                  codec_mode_i,
  input  logic [15:0]           max_payload_i,
  output rtpvp_pkg::res_item_t  result_o
);

  localparam logic [6:0] BASE7 = 7'(rtpvp_pkg::BASE_HEADER_BYTES);

  logic [15:0] idx_q, idx_d;
  logic [3:0]  csrc_q, csrc_d;
  logic        xflag_q, xflag_d;
  logic        marker_q, marker_d;
  logic [6:0]  kind_q, kind_d;
  logic [15:0] seq_q, seq_d;
  logic [31:0] stamp_q, stamp_d;
  logic [31:0] src_q, src_d;
  logic [18:0] hlen_q, hlen_d;
  logic [7:0]  ext_hi_q, ext_hi_d;
  logic [7:0]  head_q [3];
  logic [7:0]  head_d [3];

  logic [7:0]  b;
  logic [15:0] len;
  logic [6:0]  csrc_end, hl0;
  logic        ext, hi_hit, lo_hit, ext_pend, cap;
  logic [18:0] hl_base, idx19, head_ofs, hl_fin;
  logic [15:0] pay_len;
  logic [7:0]  p [3];
  logic [5:0]  nal;
  logic        start, mk;

  assign b   = item_i.data_byte;
  assign len = item_i.packet_length;

  // Header capture, header length and payload head tracking
  always_comb begin
    idx_d    = (idx_q != rtpvp_pkg::INDEX_SAT) ? idx_q + 16'd1 : idx_q;
    csrc_d   = csrc_q;
    xflag_d  = xflag_q;
    marker_d = marker_q;
    kind_d   = kind_q;
    seq_d    = seq_q;
    stamp_d  = stamp_q;
    src_d    = src_q;
    head_d   = head_q;

    if (idx_q == 16'd0) begin
      csrc_d  = 4'(b & rtpvp_pkg::CSRC_MASK);
      xflag_d = |(b & rtpvp_pkg::EXT_MASK);
    end else if (idx_q == 16'd1) begin
      marker_d = |(b & rtpvp_pkg::START_MASK);
      kind_d   = 7'(b & rtpvp_pkg::KIND_MASK);
    end else if (idx_q inside {[16'd2:16'd3]}) begin
      seq_d = {seq_q[7:0], b};
    end else if (idx_q inside {[16'd4:16'd7]}) begin
      stamp_d = {stamp_q[23:0], b};
    end else if (idx_q inside {[16'd8:16'd11]}) begin
      src_d = {src_q[23:0], b};
    end

    // CSRC words count only when the packet extends past them
    csrc_end = BASE7 + {1'b0, csrc_d, 2'b00};
    hl0      = (csrc_d != 4'd0 && len > {9'd0, csrc_end}) ? csrc_end : BASE7;
    ext      = xflag_d && (len > {9'd0, hl0} + 16'd4);
    hi_hit   = ext && (idx_q == {9'd0, hl0} + 16'd2);
    lo_hit   = ext && (idx_q == {9'd0, hl0} + 16'd3);
    ext_pend = ext && (idx_q <= {9'd0, hl0} + 16'd3);

    hl_base  = (idx_q == 16'd0) ? {12'd0, hl0} : hlen_q;
    ext_hi_d = hi_hit ? b : ext_hi_q;
    hlen_d   = lo_hit ? hl_base + {({1'b0, ext_hi_q, b} + 17'd1), 2'b00} : hl_base;

    // Keep the first three payload bytes
    idx19    = {3'd0, idx_q};
    head_ofs = idx19 - hlen_d;
    cap      = !ext_pend && (idx19 >= hlen_d) && (head_ofs < 19'd3);
    if (cap) begin
      head_d[head_ofs[1:0]] = b;
    end

    // Extension length low byte never arrived: count it as zero
    hl_fin = (ext && idx_q < {9'd0, hl0} + 16'd3)
           ? hlen_d + {({1'b0, ext_hi_d, 8'h00} + 17'd1), 2'b00}
           : hlen_d;
  end

  // Status, NAL inspection and result assembly
  always_comb begin
    pay_len = len - hl_fin[15:0];
    for (int k = 0; k < 3; k++) begin
      p[k] = (({1'b0, hl_fin} + 20'(k)) < {4'd0, len}) ? head_d[k] : 8'h00;
    end

    start = 1'b0;
    mk    = marker_d;
    if (codec_mode_i == rtpvp_pkg::CODEC_H264) begin
      nal = 6'(p[0] & rtpvp_pkg::NAL264_MASK);
      if (nal == rtpvp_pkg::NAL264_FU_A || nal == rtpvp_pkg::NAL264_IDR ||
          nal == rtpvp_pkg::NAL_SLICE) begin
        start = p[1][7];
      end
      if (nal inside {[rtpvp_pkg::NAL264_SEI:rtpvp_pkg::NAL264_PPS]}) begin
        mk = 1'b0;
      end
    end else begin
      nal = p[0][6:1];
      if (nal == rtpvp_pkg::NAL265_FU || nal == rtpvp_pkg::NAL265_IDR ||
          nal == rtpvp_pkg::NAL_SLICE) begin
        start = p[2][7];
      end
    end

    result_o = '0;
    result_o.result_valid_last = 1'b1;
    if (len <= 16'(rtpvp_pkg::BASE_HEADER_BYTES)) begin
      result_o.parse_status = rtpvp_pkg::ST_TOO_SHORT;
    end else if (hl_fin >= {3'd0, len}) begin
      result_o.parse_status = rtpvp_pkg::ST_HEADER_END;
    end else if (pay_len > max_payload_i) begin
      result_o.parse_status = rtpvp_pkg::ST_TOO_LONG;
    end else begin
      result_o.parse_status    = rtpvp_pkg::ST_OK;
      result_o.marker          = mk;
      result_o.payload_type    = kind_d;
      result_o.sequence_number = seq_d;
      result_o.time_stamp      = stamp_d;
      result_o.source_id       = src_d;
      result_o.payload_offset  = hl_fin[15:0];
      result_o.payload_length  = pay_len;
      result_o.nal_type        = nal;
      result_o.frame_start     = start;
    end
  end

  // Advance per byte; clear all packet state after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      csrc_q   <= '0;
      xflag_q  <= 1'b0;
      marker_q <= 1'b0;
      kind_q   <= '0;
      seq_q    <= '0;
      stamp_q  <= '0;
      src_q    <= '0;
      hlen_q   <= 19'(rtpvp_pkg::BASE_HEADER_BYTES);
      ext_hi_q <= '0;
      head_q   <= '{default: 8'h00};
    end else if (fire_i && item_i.last_byte) begin
      idx_q    <= '0;
      csrc_q   <= '0;
      xflag_q  <= 1'b0;
      marker_q <= 1'b0;
      kind_q   <= '0;
      seq_q    <= '0;
      stamp_q  <= '0;
      src_q    <= '0;
      hlen_q   <= 19'(rtpvp_pkg::BASE_HEADER_BYTES);
      ext_hi_q <= '0;
      head_q   <= '{default: 8'h00};
    end else if (fire_i) begin
      idx_q    <= idx_d;
      csrc_q   <= csrc_d;
      xflag_q  <= xflag_d;
      marker_q <= marker_d;
      kind_q   <= kind_d;
      seq_q    <= seq_d;
      stamp_q  <= stamp_d;
      src_q    <= src_d;
      hlen_q   <= hlen_d;
      ext_hi_q <= ext_hi_d;
      head_q   <= head_d;
    end
  end

endmodule

// ----- sv/rtpvp_out_stage.sv -----
// ----------------------------------------------------------------------------
// rtpvp_out_stage: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtpvp_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  rtpvp_pkg::res_item_t  result_i,
  rtpvp_res_if.source           res_o,
  output logic                  free_o
);

  logic                 valid_q;
  rtpvp_pkg::res_item_t data_q;

  // Room for a new result when empty or when the held one leaves now
  assign free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign res_o.valid = valid_q;
  assign res_o.data  = data_q;

endmodule

// ----- sv/rtp_video_header_parser.sv -----
// ----------------------------------------------------------------------------
// rtp_video_header_parser: one byte request per cycle, except while the input stalls.
// A last byte passes the input register, then its result the result register.
// Input stalls only while a last byte waits on a full result register.
// Reset clears packet state; codec mode goes to H.264, payload limit to 1500.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtp_video_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  rtpvp_in_if.sink    pkt_i,
  rtpvp_res_if.source res_o
);

  logic                 codec_mode_q;
  logic [15:0]          max_payload_q;
  logic                 s1_valid, advance, load, out_free;
  rtpvp_pkg::in_item_t  s1_item;
  rtpvp_pkg::res_item_t result;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_mode_q  <= rtpvp_pkg::CODEC_H264;
      max_payload_q <= rtpvp_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rtpvp_pkg::CFG_CODEC_MODE:  codec_mode_q  <= cfg_wdata_i[0];
        rtpvp_pkg::CFG_MAX_PAYLOAD: max_payload_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A held byte moves on unless it needs the result register and that is full
  assign advance = s1_valid && (!s1_item.last_byte || out_free);
  assign load    = advance && s1_item.last_byte;

  rtpvp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pkt_i     (pkt_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  rtpvp_parse_core u_parse_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (advance),
    .item_i        (s1_item),
    .codec_mode_i  (codec_mode_q),
    .max_payload_i (max_payload_q),
    .result_o      (result)
  );

  rtpvp_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .result_i (result),
    .res_o    (res_o),
    .free_o   (out_free)
  );

endmodule
